// File: src/drtc_pkg.sv
// ----------------------------------------------------------------------------
// drtc_pkg
// Shared widths, register map and cell sideband types for the throttle
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package drtc_pkg;

    localparam int POS_W  = 27;
    localparam int VEL_W  = 24;
    localparam int SQ_W   = 54;
    localparam int MAG_W  = 27;
    localparam int DABS_W = 51;
    localparam int DOT_W  = 53;
    localparam int Q_W    = 26;
    localparam int HT_W   = 36;
    localparam int ERR_W  = 38;
    localparam int THR_W  = 16;
    localparam int CS_W   = 2;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [CS_W-1:0] CS_NONE = 2'd0;
    localparam logic [CS_W-1:0] CS_LOW  = 2'd1;
    localparam logic [CS_W-1:0] CS_HIGH = 2'd2;

    localparam logic [2:0] REG_HEIGHT_GAIN = 3'd0;
    localparam logic [2:0] REG_LOOP_GAIN   = 3'd1;
    localparam logic [2:0] REG_BIAS        = 3'd2;
    localparam logic [2:0] REG_BASE_RATE   = 3'd3;
    localparam logic [2:0] REG_RADIUS      = 3'd4;

    typedef struct packed {
        logic [19:0] height_gain;
        logic [15:0] loop_gain;
        logic [15:0] throttle_bias;
        logic [15:0] base_descent_rate;
        logic [25:0] planet_radius;
    } t_cfg;

    typedef struct packed {
        logic              neg;
        logic [DABS_W-1:0] dabs;
    } t_sqrt_side;

    typedef struct packed {
        logic signed [POS_W-1:0] alt;
        logic signed [HT_W-1:0]  hterm;
        logic                    neg;
        logic                    mag_zero;
    } t_div_side;

endpackage

`default_nettype wire

// File: src/descent_rate_throttle_controller.sv
// ----------------------------------------------------------------------------
// descent_rate_throttle_controller
// Proportional descent-rate controller with throttle saturation.
// ----------------------------------------------------------------------------
// An item (position and velocity vectors) is taken at each clock edge where
// start is high and busy is low. busy is held low, so one item can enter in
// every cycle and items overlap fully in the pipeline.
// Each result appears on o_throttle, o_clamp_state and o_altitude for one
// cycle with o_valid high, in the order the items came in. The pipeline is a
// chain of 27 square-root cells (one root bit each) and 26 divider cells (one
// quotient bit each), plus 8 stages of multipliers, adders and clamping.
// There is no back pressure: the receiver must take each result as shown.
// Registers are written and read over the APB-style port; write them only
// while no item is in flight.
// Synchronous reset empties the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module descent_rate_throttle_controller (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [26:0]          i_pos_x,
    input  wire logic signed [26:0]          i_pos_y,
    input  wire logic signed [26:0]          i_pos_z,
    input  wire logic signed [23:0]          i_vel_x,
    input  wire logic signed [23:0]          i_vel_y,
    input  wire logic signed [23:0]          i_vel_z,
    output logic                             o_valid,
    output logic             [15:0]          o_throttle,
    output logic             [1:0]           o_clamp_state,
    output logic signed      [26:0]          o_altitude,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [drtc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [drtc_pkg::DATA_W-1:0] pwdata,
    output logic      [drtc_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int NS  = drtc_pkg::MAG_W;
    localparam int ND  = drtc_pkg::Q_W;
    localparam int SSW = $bits(drtc_pkg::t_sqrt_side);
    localparam int DSW = $bits(drtc_pkg::t_div_side);

    drtc_pkg::t_cfg w_cfg;

    drtc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // input stage
    logic                     r_a_valid;
    logic signed [26:0]       r_px, r_py, r_pz;
    logic signed [23:0]       r_vx, r_vy, r_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= i_pos_x;
        r_py <= i_pos_y;
        r_pz <= i_pos_z;
        r_vx <= i_vel_x;
        r_vy <= i_vel_y;
        r_vz <= i_vel_z;
    end

    // products
    logic                     r_b_valid;
    logic [52:0]              r_sqx, r_sqy, r_sqz;
    logic signed [50:0]       r_dx, r_dy, r_dz;
    logic signed [53:0]       w_sqx, w_sqy, w_sqz;

    always_comb begin
        w_sqx = r_px * r_px;
        w_sqy = r_py * r_py;
        w_sqz = r_pz * r_pz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqx <= w_sqx[52:0];
        r_sqy <= w_sqy[52:0];
        r_sqz <= w_sqz[52:0];
        r_dx  <= r_px * r_vx;
        r_dy  <= r_py * r_vy;
        r_dz  <= r_pz * r_vz;
    end

    // sums
    logic                          r_c_valid;
    logic [drtc_pkg::SQ_W-1:0]     r_sq;
    drtc_pkg::t_sqrt_side          r_c_side;
    logic signed [drtc_pkg::DOT_W-1:0] w_dot;
    logic [drtc_pkg::DOT_W-1:0]    w_dabs;

    always_comb begin
        w_dot  = drtc_pkg::DOT_W'(r_dx) + drtc_pkg::DOT_W'(r_dy)
               + drtc_pkg::DOT_W'(r_dz);
        w_dabs = w_dot[drtc_pkg::DOT_W-1] ? -w_dot : w_dot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq          <= drtc_pkg::SQ_W'(r_sqx) + drtc_pkg::SQ_W'(r_sqy)
                       + drtc_pkg::SQ_W'(r_sqz);
        r_c_side.neg  <= w_dot[drtc_pkg::DOT_W-1];
        r_c_side.dabs <= w_dabs[drtc_pkg::DABS_W-1:0];
    end

    // square root chain
    logic                       s_valid [NS+1];
    logic [drtc_pkg::SQ_W-1:0]  s_rem   [NS+1];
    logic [drtc_pkg::MAG_W-1:0] s_root  [NS+1];
    logic [SSW-1:0]             s_side  [NS+1];

    assign s_valid[0] = r_c_valid;
    assign s_rem[0]   = r_sq;
    assign s_root[0]  = '0;
    assign s_side[0]  = r_c_side;

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        drtc_sqrt_cell #(.IDX(NS - 1 - g), .SW(SSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_side  (s_side[g]),
            .o_valid (s_valid[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    // altitude
    drtc_pkg::t_sqrt_side       w_s_out;
    logic signed [28:0]         w_alt_raw;
    logic                       r_d_valid;
    logic signed [26:0]         r_d_alt;
    logic [drtc_pkg::MAG_W-1:0] r_d_mag;
    drtc_pkg::t_sqrt_side       r_d_side;

    always_comb begin
        w_s_out   = s_side[NS];
        w_alt_raw = $signed({2'b00, s_root[NS]}) - $signed({3'b000, w_cfg.planet_radius});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= s_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_alt  <= (w_alt_raw > 29'sd67108863) ? 27'sd67108863 : w_alt_raw[26:0];
        r_d_mag  <= s_root[NS];
        r_d_side <= w_s_out;
    end

    // height term
    logic                       r_e_valid;
    drtc_pkg::t_div_side        r_e_side;
    logic [drtc_pkg::MAG_W-1:0] r_e_mag;
    logic [drtc_pkg::DABS_W-1:0] r_e_dabs;
    logic signed [47:0]         w_hprod;

    assign w_hprod = $signed({1'b0, w_cfg.height_gain}) * r_d_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_side.alt      <= r_d_alt;
        r_e_side.hterm    <= w_hprod[47:12];
        r_e_side.neg      <= r_d_side.neg;
        r_e_side.mag_zero <= (r_d_mag == '0);
        r_e_mag           <= r_d_mag;
        r_e_dabs          <= r_d_side.dabs;
    end

    // divider chain
    logic                        d_valid [ND+1];
    logic [drtc_pkg::DABS_W-1:0] d_rem   [ND+1];
    logic [drtc_pkg::MAG_W-1:0]  d_mag   [ND+1];
    logic [drtc_pkg::Q_W-1:0]    d_quo   [ND+1];
    logic [DSW-1:0]              d_side  [ND+1];

    assign d_valid[0] = r_e_valid;
    assign d_rem[0]   = r_e_dabs;
    assign d_mag[0]   = r_e_mag;
    assign d_quo[0]   = '0;
    assign d_side[0]  = r_e_side;

    for (genvar g = 0; g < ND; g++) begin : g_div
        drtc_div_cell #(.IDX(ND - 1 - g), .SW(DSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_valid[g]),
            .i_rem   (d_rem[g]),
            .i_mag   (d_mag[g]),
            .i_quo   (d_quo[g]),
            .i_side  (d_side[g]),
            .o_valid (d_valid[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_mag   (d_mag[g+1]),
            .o_quo   (d_quo[g+1]),
            .o_side  (d_side[g+1])
        );
    end

    // rate error
    drtc_pkg::t_div_side        w_d_out;
    logic signed [drtc_pkg::Q_W:0]     w_radial;
    logic signed [drtc_pkg::ERR_W-1:0] w_err;
    logic                       r_f_valid;
    logic signed [drtc_pkg::ERR_W-1:0] r_f_err;
    logic signed [26:0]         r_f_alt;

    always_comb begin
        w_d_out  = d_side[ND];
        if (w_d_out.mag_zero) begin
            w_radial = '0;
        end else if (w_d_out.neg) begin
            w_radial = -$signed({1'b0, d_quo[ND]});
        end else begin
            w_radial = $signed({1'b0, d_quo[ND]});
        end
        w_err = -(drtc_pkg::ERR_W'($signed({1'b0, w_cfg.base_descent_rate}))
                + drtc_pkg::ERR_W'(w_d_out.hterm) + drtc_pkg::ERR_W'(w_radial));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= d_valid[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_err <= w_err;
        r_f_alt <= w_d_out.alt;
    end

    // gain
    logic                 r_g_valid;
    logic signed [54:0]   r_g_prod;
    logic signed [26:0]   r_g_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_prod <= $signed({1'b0, w_cfg.loop_gain}) * r_f_err;
        r_g_alt  <= r_f_alt;
    end

    // bias and clamp
    logic signed [51:0]   w_sum;
    logic                 r_h_valid;
    logic [15:0]          r_h_thr;
    logic [1:0]           r_h_cs;
    logic signed [26:0]   r_h_alt;
    logic [15:0]          n_thr;
    logic [1:0]           n_cs;

    always_comb begin
        w_sum = 52'($signed(r_g_prod[54:4])) + $signed({36'd0, w_cfg.throttle_bias});
        priority if (w_sum <= 52'sd0) begin
            n_thr = '0;
            n_cs  = drtc_pkg::CS_LOW;
        end else if (w_sum >= 52'sd65535) begin
            n_thr = 16'hFFFF;
            n_cs  = drtc_pkg::CS_HIGH;
        end else begin
            n_thr = w_sum[15:0];
            n_cs  = drtc_pkg::CS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else begin
            r_h_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_thr <= n_thr;
        r_h_cs  <= n_cs;
        r_h_alt <= r_g_alt;
    end

    assign o_valid       = r_h_valid;
    assign o_throttle    = r_h_thr;
    assign o_clamp_state = r_h_cs;
    assign o_altitude    = r_h_alt;

endmodule

`default_nettype wire

// File: src/drtc_cfg.sv
// ----------------------------------------------------------------------------
// drtc_cfg
// Register file with write and read access over the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module drtc_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [drtc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [drtc_pkg::DATA_W-1:0] pwdata,
    output logic      [drtc_pkg::DATA_W-1:0] prdata,
    output drtc_pkg::t_cfg                   o_cfg
);

    drtc_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;

    assign w_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_gain       <= 20'd17826;
            r_cfg.loop_gain         <= 16'd7373;
            r_cfg.throttle_bias     <= 16'd19661;
            r_cfg.base_descent_rate <= 16'd128;
            r_cfg.planet_radius     <= 26'd3386000;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                drtc_pkg::REG_HEIGHT_GAIN: r_cfg.height_gain       <= pwdata[19:0];
                drtc_pkg::REG_LOOP_GAIN:   r_cfg.loop_gain         <= pwdata[15:0];
                drtc_pkg::REG_BIAS:        r_cfg.throttle_bias     <= pwdata[15:0];
                drtc_pkg::REG_BASE_RATE:   r_cfg.base_descent_rate <= pwdata[15:0];
                drtc_pkg::REG_RADIUS:      r_cfg.planet_radius     <= pwdata[25:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            drtc_pkg::REG_HEIGHT_GAIN: prdata = {12'd0, r_cfg.height_gain};
            drtc_pkg::REG_LOOP_GAIN:   prdata = {16'd0, r_cfg.loop_gain};
            drtc_pkg::REG_BIAS:        prdata = {16'd0, r_cfg.throttle_bias};
            drtc_pkg::REG_BASE_RATE:   prdata = {16'd0, r_cfg.base_descent_rate};
            drtc_pkg::REG_RADIUS:      prdata = {6'd0, r_cfg.planet_radius};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/drtc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// drtc_sqrt_cell
// One root bit of the integer square root, registered toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module drtc_sqrt_cell #(
    parameter int IDX = 0,
    parameter int SW  = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [drtc_pkg::SQ_W-1:0]  i_rem,
    input  wire logic [drtc_pkg::MAG_W-1:0] i_root,
    input  wire logic [SW-1:0]              i_side,
    output logic                            o_valid,
    output logic      [drtc_pkg::SQ_W-1:0]  o_rem,
    output logic      [drtc_pkg::MAG_W-1:0] o_root,
    output logic      [SW-1:0]              o_side
);

    localparam int TW = drtc_pkg::SQ_W + 2;

    logic [TW-1:0]              w_trial;
    logic                       w_take;
    logic                       r_valid;
    logic [drtc_pkg::SQ_W-1:0]  r_rem;
    logic [drtc_pkg::MAG_W-1:0] r_root;
    logic [SW-1:0]              r_side;
    logic [drtc_pkg::SQ_W-1:0]  n_rem;
    logic [drtc_pkg::MAG_W-1:0] n_root;

    always_comb begin
        w_trial = ({{(TW-drtc_pkg::MAG_W){1'b0}}, i_root} << (IDX + 1))
                | (TW'(1) << (2 * IDX));
        w_take  = {2'b00, i_rem} >= w_trial;
        n_rem   = w_take ? i_rem - w_trial[drtc_pkg::SQ_W-1:0] : i_rem;
        n_root  = w_take ? i_root | (drtc_pkg::MAG_W'(1) << IDX) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: src/drtc_div_cell.sv
// ----------------------------------------------------------------------------
// drtc_div_cell
// One quotient bit of the restoring divider, registered toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module drtc_div_cell #(
    parameter int IDX = 0,
    parameter int SW  = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [drtc_pkg::DABS_W-1:0] i_rem,
    input  wire logic [drtc_pkg::MAG_W-1:0]  i_mag,
    input  wire logic [drtc_pkg::Q_W-1:0]    i_quo,
    input  wire logic [SW-1:0]               i_side,
    output logic                             o_valid,
    output logic      [drtc_pkg::DABS_W-1:0] o_rem,
    output logic      [drtc_pkg::MAG_W-1:0]  o_mag,
    output logic      [drtc_pkg::Q_W-1:0]    o_quo,
    output logic      [SW-1:0]               o_side
);

    localparam int DW = drtc_pkg::MAG_W + drtc_pkg::Q_W;

    logic [DW-1:0]               w_div;
    logic                        w_take;
    logic                        r_valid;
    logic [drtc_pkg::DABS_W-1:0] r_rem;
    logic [drtc_pkg::MAG_W-1:0]  r_mag;
    logic [drtc_pkg::Q_W-1:0]    r_quo;
    logic [SW-1:0]               r_side;
    logic [drtc_pkg::DABS_W-1:0] n_rem;
    logic [drtc_pkg::Q_W-1:0]    n_quo;

    always_comb begin
        w_div  = {{(DW-drtc_pkg::MAG_W){1'b0}}, i_mag} << IDX;
        w_take = {{(DW-drtc_pkg::DABS_W){1'b0}}, i_rem} >= w_div;
        n_rem  = w_take ? i_rem - w_div[drtc_pkg::DABS_W-1:0] : i_rem;
        n_quo  = w_take ? i_quo | (drtc_pkg::Q_W'(1) << IDX) : i_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_mag  <= i_mag;
        r_quo  <= n_quo;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_mag   = r_mag;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: src/drtc_checker.sv
// ----------------------------------------------------------------------------
// drtc_checker
// Port-level checks on result coding and the always-open input.
// ----------------------------------------------------------------------------
`default_nettype none

module drtc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [15:0] o_throttle,
    input wire logic [1:0]  o_clamp_state
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_cs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_clamp_state == drtc_pkg::CS_NONE ||
                     o_clamp_state == drtc_pkg::CS_LOW ||
                     o_clamp_state == drtc_pkg::CS_HIGH))
        else $error("bad clamp code");

    a_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamp_state == drtc_pkg::CS_LOW) |-> o_throttle == 16'd0)
        else $error("low clamp throttle");

    a_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamp_state == drtc_pkg::CS_HIGH) |-> o_throttle == 16'hFFFF)
        else $error("high clamp throttle");

    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamp_state == drtc_pkg::CS_NONE)
            |-> (o_throttle != 16'd0 && o_throttle != 16'hFFFF))
        else $error("unclamped throttle at limit");

endmodule

bind descent_rate_throttle_controller drtc_checker u_drtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_throttle    (o_throttle),
    .o_clamp_state (o_clamp_state)
);

`default_nettype wire

// File: bench/descent_rate_throttle_controller_tb.sv
// ----------------------------------------------------------------------------
// descent_rate_throttle_controller_tb
// Drives position and velocity items through the throttle controller under
// several register settings, with random idle cycles on the input side.
// Every accepted item is run through an integer model of the controller and
// each strobed result is compared in order against the predicted throttle,
// clamp state and altitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module descent_rate_throttle_controller_tb;

    typedef struct {
        logic [drtc_pkg::THR_W-1:0]        thr;
        logic [drtc_pkg::CS_W-1:0]         cs;
        logic signed [drtc_pkg::POS_W-1:0] alt;
    } t_throttle_result;

    class throttle_scoreboard;
        drtc_pkg::t_cfg cfg;
        t_throttle_result pending[$];
        int errors;

        function new();
            errors = 0;
            load_defaults();
        endfunction

        function void load_defaults();
            cfg.height_gain       = 20'd17826;
            cfg.loop_gain         = 16'd7373;
            cfg.throttle_bias     = 16'd19661;
            cfg.base_descent_rate = 16'd128;
            cfg.planet_radius     = 26'd3386000;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                drtc_pkg::REG_HEIGHT_GAIN: cfg.height_gain       = v[19:0];
                drtc_pkg::REG_LOOP_GAIN:   cfg.loop_gain         = v[15:0];
                drtc_pkg::REG_BIAS:        cfg.throttle_bias     = v[15:0];
                drtc_pkg::REG_BASE_RATE:   cfg.base_descent_rate = v[15:0];
                drtc_pkg::REG_RADIUS:      cfg.planet_radius     = v[25:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function void note_item(longint px, longint py, longint pz,
                                longint vx, longint vy, longint vz);
            t_throttle_result r;
            longint mag, alt, dot, radial, hterm, err, p, sum;
            mag = longint'(int_sqrt(px * px + py * py + pz * pz));
            alt = mag - longint'(cfg.planet_radius);
            if (alt > 67108863) alt = 67108863;
            if (alt < -67108864) alt = -67108864;
            dot = px * vx + py * vy + pz * vz;
            radial = (mag == 0) ? 0 : dot / mag;
            hterm = (longint'(cfg.height_gain) * alt) >>> 12;
            err = -(longint'(cfg.base_descent_rate) + hterm + radial);
            p = (longint'(cfg.loop_gain) * err) >>> 4;
            sum = longint'(cfg.throttle_bias) + p;
            if (sum <= 0) begin
                r.thr = '0;
                r.cs = drtc_pkg::CS_LOW;
            end else if (sum >= 65535) begin
                r.thr = 16'hFFFF;
                r.cs = drtc_pkg::CS_HIGH;
            end else begin
                r.thr = sum[15:0];
                r.cs = drtc_pkg::CS_NONE;
            end
            r.alt = alt[26:0];
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [15:0] thr, logic [1:0] cs, logic signed [26:0] alt);
            t_throttle_result e;
            if (pending.size() == 0) begin
                report("result with no item pending");
            end else begin
                e = pending.pop_front();
                if (thr !== e.thr)
                    report($sformatf("throttle %0d, want %0d", thr, e.thr));
                if (cs !== e.cs)
                    report($sformatf("clamp_state %0d, want %0d", cs, e.cs));
                if (alt !== e.alt)
                    report($sformatf("altitude %0d, want %0d", alt, e.alt));
            end
        endtask
    endclass

    logic i_clk, i_rst_n, start, busy;
    logic signed [26:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [23:0] i_vel_x, i_vel_y, i_vel_z;
    logic o_valid;
    logic [15:0] o_throttle;
    logic [1:0] o_clamp_state;
    logic signed [26:0] o_altitude;
    logic psel, penable, pwrite, pready;
    logic [drtc_pkg::ADDR_W-1:0] paddr;
    logic [drtc_pkg::DATA_W-1:0] pwdata, prdata;

    throttle_scoreboard sb;
    bit idle_on;

    descent_rate_throttle_controller uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_vel_x(i_vel_x), .i_vel_y(i_vel_y), .i_vel_z(i_vel_z),
        .o_valid(o_valid), .o_throttle(o_throttle), .o_clamp_state(o_clamp_state),
        .o_altitude(o_altitude), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("descent_rate_throttle_controller_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_throttle, o_clamp_state, o_altitude);
            if (start && !busy)
                sb.note_item(i_pos_x, i_pos_y, i_pos_z, i_vel_x, i_vel_y, i_vel_z);
        end
    end

    task automatic send_item(logic [26:0] px, logic [26:0] py, logic [26:0] pz,
                             logic [23:0] vx, logic [23:0] vy, logic [23:0] vz);
        while (idle_on && $urandom_range(99) < 38) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_vel_x <= vx; i_vel_y <= vy; i_vel_z <= vz;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(logic [31:0] hg, logic [31:0] lg, logic [31:0] tb,
                             logic [31:0] br, logic [31:0] rad);
        write_reg(drtc_pkg::REG_HEIGHT_GAIN, hg);
        write_reg(drtc_pkg::REG_LOOP_GAIN, lg);
        write_reg(drtc_pkg::REG_BIAS, tb);
        write_reg(drtc_pkg::REG_BASE_RATE, br);
        write_reg(drtc_pkg::REG_RADIUS, rad);
    endtask

    task automatic directed_items();
        logic [26:0] r;
        r = {1'b0, sb.cfg.planet_radius};
        send_item(0, 0, 0, 0, 0, 0);
        send_item(0, 0, 0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_item(27'h3FFFFFF, 27'h3FFFFFF, 27'h3FFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_item(27'h4000000, 27'h4000000, 27'h4000000, 24'h800000, 24'h800000, 24'h800000);
        send_item(27'h3FFFFFF, 27'h4000000, 27'h3FFFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_item(r, 0, 0, 0, 0, 0);
        send_item(-r, 0, 0, 24'h000100, 0, 0);
        send_item(0, r + 27'd500, 0, 0, 24'hFFF000, 0);
        send_item(0, 0, r - 27'd500, 0, 0, 24'h001000);
        send_item(r + 27'd20000, 0, 0, 24'hFF0000, 0, 0);
        send_item(1, 0, 0, 24'h7FFFFF, 0, 0);
        send_item(0, 27'h7FFFFFF, 0, 0, 24'h800000, 0);
    endtask

    task automatic random_items(int n);
        logic [26:0] px, py, pz;
        logic [23:0] vx, vy, vz;
        int mode;
        repeat (n) begin
            mode = $urandom_range(9);
            px = $urandom; py = $urandom; pz = $urandom;
            vx = $urandom; vy = $urandom; vz = $urandom;
            if (mode < 6) begin
                px = {1'b0, sb.cfg.planet_radius} + 27'($urandom_range(40000)) - 27'd20000;
                py = 27'($signed($urandom_range(200000)) - 100000);
                pz = 27'($signed($urandom_range(200000)) - 100000);
                if ($urandom_range(1)) px = -px;
                vx = 24'($signed($urandom_range(40000)) - 20000);
                vy = 24'($signed($urandom_range(4000)) - 2000);
                vz = 24'($signed($urandom_range(4000)) - 2000);
            end else if (mode == 6) begin
                px = 27'($signed($urandom_range(6)) - 3);
                py = 27'($signed($urandom_range(6)) - 3);
                pz = 27'($signed($urandom_range(6)) - 3);
            end
            send_item(px, py, pz, vx, vy, vz);
        end
    endtask

    initial begin
        sb = new();
        idle_on = 1'b1;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_pos_x <= '0; i_pos_y <= '0; i_pos_z <= '0;
        i_vel_x <= '0; i_vel_y <= '0; i_vel_z <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        random_items(60);
        drain();

        // out-of-map writes must leave the registers alone
        write_reg(3'd5, 32'hFFFFFFFF);
        write_reg(3'd6, 32'h12345678);
        write_reg(3'd7, 32'hFFFFFFFF);
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        directed_items();
        random_items(30);
        drain();

        write_all(0, 0, 0, 0, 0);
        directed_items();
        random_items(30);
        drain();

        write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(4000000));
        directed_items();
        random_items(40);
        drain();

        // long stretch without idle cycles
        idle_on = 1'b0;
        write_all(17826, 7373, 19661, 128, 3386000);
        random_items(120);
        idle_on = 1'b1;
        drain();

        write_all($urandom_range(100000), $urandom, $urandom, $urandom_range(2000),
                  $urandom);
        random_items(60);
        drain();

        if (sb.errors == 0)
            $display("descent_rate_throttle_controller_tb OK");
        else
            $display("descent_rate_throttle_controller_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
src/drtc_pkg.sv
src/drtc_cfg.sv
src/drtc_sqrt_cell.sv
src/drtc_div_cell.sv
src/descent_rate_throttle_controller.sv
src/drtc_checker.sv
bench/descent_rate_throttle_controller_tb.sv
